[rtl/core/nsc_pkg.sv]
`default_nettype none

package nsc_pkg;

    localparam int unsigned CharW  = 8;
    localparam int unsigned CodeW  = 24;
    localparam int unsigned CfgIdxW = 8;
    localparam int unsigned TdataOutW = 24;

    // parser phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_HEX1 = 2'd2;
    localparam logic [1:0] PH_HEX2 = 2'd3;

    // check status codes
    localparam logic [1:0] ST_VALID  = 2'd0;
    localparam logic [1:0] ST_BADSUM = 2'd1;
    localparam logic [1:0] ST_BADID  = 2'd2;

    // sentence kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_FIRST  = 2'd1;
    localparam logic [1:0] KIND_SECOND = 2'd2;
    localparam logic [1:0] KIND_THIRD  = 2'd3;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_FIRST  = 8'd0;
    localparam logic [CfgIdxW-1:0] REG_SECOND = 8'd1;
    localparam logic [CfgIdxW-1:0] REG_THIRD  = 8'd2;

    localparam logic [CodeW-1:0] RST_FIRST  = 24'h474741;  // GGA
    localparam logic [CodeW-1:0] RST_SECOND = 24'h524D43;  // RMC
    localparam logic [CodeW-1:0] RST_THIRD  = 24'h5A4441;  // ZDA

    localparam logic [CharW-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CharW-1:0] CH_STAR   = 8'h2A;

    // body bytes 2..4 (zero based) are the formatter letters
    localparam logic [2:0] POS_FMT_START = 3'd2;
    localparam logic [2:0] POS_FMT_DONE  = 3'd5;

    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       status;
        logic [CharW-1:0] computed;
        logic [CharW-1:0] received;
    } nsc_result_t;

    typedef struct packed {
        logic       bad;
        logic [3:0] value;
    } nsc_hex_t;

    // ASCII hex digit decode; bad digits read as zero
    function automatic nsc_hex_t hex_decode(input logic [CharW-1:0] c);
        nsc_hex_t h;
        h.bad   = 1'b0;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            h.value = 4'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            h.value = 4'(c - 8'h57);
        end
        else
        begin
            h.bad = 1'b1;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

[rtl/core/nsc_parser.sv]
`default_nettype none

module nsc_parser (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       take,
    input  wire logic [nsc_pkg::CharW-1:0]  char_byte,
    input  wire logic [nsc_pkg::CodeW-1:0]  first_code,
    input  wire logic [nsc_pkg::CodeW-1:0]  second_code,
    input  wire logic [nsc_pkg::CodeW-1:0]  third_code,
    output logic                            in_last_digit,
    output logic                            emit,
    output nsc_pkg::nsc_result_t            result
);
    import nsc_pkg::*;

    logic [1:0]       phase_reg, phase_next;
    logic [CharW-1:0] xor_reg, xor_next;
    logic [2:0]       pos_reg, pos_next;
    logic [CodeW-1:0] fmt_reg, fmt_next;
    logic [3:0]       hi_reg, hi_next;
    logic             herr_reg, herr_next;

    nsc_hex_t         hex;
    logic [CharW-1:0] rx_sum;
    logic [1:0]       kind;

    assign hex           = hex_decode(char_byte);
    assign rx_sum        = {hi_reg, hex.value};
    assign in_last_digit = (phase_reg == PH_HEX2);

    always_comb
    begin
        kind = KIND_NONE;
        if (pos_reg >= POS_FMT_DONE)
        begin
            priority if (fmt_reg == first_code)  kind = KIND_FIRST;
            else if (fmt_reg == second_code)     kind = KIND_SECOND;
            else if (fmt_reg == third_code)      kind = KIND_THIRD;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        xor_next   = xor_reg;
        pos_next   = pos_reg;
        fmt_next   = fmt_reg;
        hi_next    = hi_reg;
        herr_next  = herr_reg;
        emit       = 1'b0;
        result.kind     = KIND_NONE;
        result.status   = ST_BADID;
        result.computed = xor_reg;
        result.received = rx_sum;
        if (kind != KIND_NONE)
        begin
            if (herr_reg || hex.bad || rx_sum != xor_reg)
            begin
                result.status = ST_BADSUM;
            end
            else
            begin
                result.status = ST_VALID;
                result.kind   = kind;
            end
        end

        if (char_byte == CH_DOLLAR)
        begin
            phase_next = PH_BODY;
            xor_next   = '0;
            pos_next   = '0;
            fmt_next   = '0;
            hi_next    = '0;
            herr_next  = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                end
                PH_BODY:
                begin
                    if (char_byte == CH_STAR)
                    begin
                        phase_next = PH_HEX1;
                    end
                    else
                    begin
                        xor_next = xor_reg ^ char_byte;
                        if (pos_reg >= POS_FMT_START && pos_reg < POS_FMT_DONE)
                        begin
                            fmt_next = {fmt_reg[CodeW-CharW-1:0], char_byte};
                        end
                        if (pos_reg < POS_FMT_DONE)
                        begin
                            pos_next = pos_reg + 3'd1;
                        end
                    end
                end
                PH_HEX1:
                begin
                    hi_next    = hex.value;
                    herr_next  = herr_reg | hex.bad;
                    phase_next = PH_HEX2;
                end
                PH_HEX2:
                begin
                    emit       = 1'b1;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            xor_reg   <= '0;
            pos_reg   <= '0;
            fmt_reg   <= '0;
            hi_reg    <= '0;
            herr_reg  <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            xor_reg   <= xor_next;
            pos_reg   <= pos_next;
            fmt_reg   <= fmt_next;
            hi_reg    <= hi_next;
            herr_reg  <= herr_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/nsc_cfg_regs.sv]
`default_nettype none

module nsc_cfg_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr_en,
    input  wire logic [nsc_pkg::CfgIdxW-1:0]  wr_index,
    input  wire logic [nsc_pkg::CodeW-1:0]    wr_data,
    output logic [nsc_pkg::CodeW-1:0]         first_code,
    output logic [nsc_pkg::CodeW-1:0]         second_code,
    output logic [nsc_pkg::CodeW-1:0]         third_code
);
    import nsc_pkg::*;

    logic [CodeW-1:0] first_reg, second_reg, third_reg;

    assign first_code  = first_reg;
    assign second_code = second_reg;
    assign third_code  = third_reg;

    // indexes past the register list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= RST_FIRST;
            second_reg <= RST_SECOND;
            third_reg  <= RST_THIRD;
        end
        else if (wr_en)
        begin
            if (wr_index == REG_FIRST)  first_reg  <= wr_data;
            if (wr_index == REG_SECOND) second_reg <= wr_data;
            if (wr_index == REG_THIRD)  third_reg  <= wr_data;
        end
    end

endmodule

`default_nettype wire

[rtl/core/nsc_out_reg.sv]
`default_nettype none

module nsc_out_reg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire nsc_pkg::nsc_result_t result,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output nsc_pkg::nsc_result_t      out_result
);
    import nsc_pkg::*;

    logic        valid_reg;
    nsc_result_t data_reg;

    assign out_valid  = valid_reg;
    assign out_result = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

endmodule

`default_nettype wire

[rtl/core/nmea_sentence_checker.sv]
`default_nettype none

// Channel    | Dir | Handshake                  | Payload
// -----------+-----+----------------------------+------------------------------------------
// s_axis     | in  | s_tvalid / s_tready        | s_tdata[7:0] char_byte
// m_axis     | out | m_tvalid / m_tready        | m_tdata: kind, status, computed, received
// cfg        | in  | cfg_valid / cfg_ready      | cfg_index, cfg_data (24-bit kind code)
//
// One byte per cycle while s_tready is high: a byte taken at an edge updates
// the sentence state at that edge, and the second checksum digit loads the
// result register at that same edge. The single output register sets the
// stall: s_tready drops only while the next byte is the last checksum digit
// and the previous result is still held. cfg_ready is always high.
// Reset clears the parser state and output valid, and restores the kind codes
// to GGA, RMC and ZDA.

module nmea_sentence_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [nsc_pkg::CharW-1:0]     s_tdata,     // [7:0] char_byte
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [nsc_pkg::TdataOutW-1:0]      m_tdata,     // [1:0] sentence_kind,
                                                            // [3:2] check_status,
                                                            // [11:4] computed_sum,
                                                            // [19:12] received_sum,
                                                            // [23:20] zero
    // configuration writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [nsc_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [nsc_pkg::CodeW-1:0]     cfg_data
);
    import nsc_pkg::*;

    logic             take;
    logic             emit;
    logic             last_digit;
    nsc_result_t      result;
    nsc_result_t      out_result;
    logic [CodeW-1:0] first_code, second_code, third_code;

    assign cfg_ready = 1'b1;

    // only the last checksum digit can produce a transaction, so only it stalls
    assign s_tready = !(last_digit && m_tvalid && !m_tready);
    assign take     = s_tvalid && s_tready;

    nsc_cfg_regs u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (cfg_valid && cfg_ready),
        .wr_index    (cfg_index),
        .wr_data     (cfg_data),
        .first_code  (first_code),
        .second_code (second_code),
        .third_code  (third_code)
    );

    nsc_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .char_byte     (s_tdata),
        .first_code    (first_code),
        .second_code   (second_code),
        .third_code    (third_code),
        .in_last_digit (last_digit),
        .emit          (emit),
        .result        (result)
    );

    nsc_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take && emit),
        .result     (result),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_result (out_result)
    );

    assign m_tdata = {4'd0, out_result.received, out_result.computed,
                      out_result.status, out_result.kind};

    // a good sentence always names a kind; a bad one never does
    a_kind_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((out_result.status == ST_VALID) == (out_result.kind != KIND_NONE)))
        else $error("kind and status disagree");

    a_valid_sum: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_result.status == ST_VALID |-> out_result.computed == out_result.received)
        else $error("valid status with checksum mismatch");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready && last_digit))
        else $error("input stalled without a held result");

    a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
        take && emit |=> m_tvalid && !last_digit)
        else $error("result load out of step with parser phase");

endmodule

`default_nettype wire

[tb/sv/nsc_sentence_monitor.sv]
// Watches the byte stream, the result stream and the register writes of the
// sentence checker. Keeps its own parser state, forms the report that each
// completed sentence should produce and compares it with what comes out.

module nsc_sentence_monitor (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [nsc_pkg::CharW-1:0]     s_tdata,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [nsc_pkg::TdataOutW-1:0] m_tdata,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [nsc_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [nsc_pkg::CodeW-1:0]     cfg_data,
    output int                                 fail_count,
    output int                                 pending
);

    import nsc_pkg::*;

    localparam int ShownMax = 10;

    logic [1:0]       phase;
    logic [7:0]       body_xor;
    logic [2:0]       body_count;
    logic [23:0]      formatter;
    logic [3:0]       upper_digit;
    logic             digit_bad;
    logic [CodeW-1:0] kind_code [3];
    nsc_result_t      reports_due [$];
    int               mismatches;

    // {bad, value}; value reads as zero when bad
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]})
            return {1'b0, c[3:0]};
        if ((c | 8'h20) inside {[8'h61:8'h66]})
            return {1'b0, 4'(c[3:0] + 4'd9)};
        return 5'b1_0000;
    endfunction

    function automatic void restart_sentence();
        body_xor    = '0;
        body_count  = '0;
        formatter   = '0;
        upper_digit = '0;
        digit_bad   = 1'b0;
    endfunction

    function automatic void take_char(input logic [7:0] c);
        logic [4:0]  d;
        nsc_result_t r;
        if (c == CH_DOLLAR)
        begin
            restart_sentence();
            phase = PH_BODY;
            return;
        end
        case (phase)
            PH_BODY:
            begin
                if (c == CH_STAR)
                begin
                    phase = PH_HEX1;
                end
                else
                begin
                    body_xor ^= c;
                    if (body_count >= POS_FMT_START && body_count < POS_FMT_DONE)
                        formatter = {formatter[15:0], c};
                    if (body_count < POS_FMT_DONE)
                        body_count++;
                end
            end
            PH_HEX1:
            begin
                d = digit_of(c);
                digit_bad   = digit_bad | d[4];
                upper_digit = d[3:0];
                phase       = PH_HEX2;
            end
            PH_HEX2:
            begin
                d = digit_of(c);
                digit_bad  = digit_bad | d[4];
                r.received = {upper_digit, d[3:0]};
                r.computed = body_xor;
                r.kind     = KIND_NONE;
                // identifier first, lowest kind wins on equal codes
                if (body_count == POS_FMT_DONE)
                begin
                    if (formatter == kind_code[0])
                        r.kind = KIND_FIRST;
                    else if (formatter == kind_code[1])
                        r.kind = KIND_SECOND;
                    else if (formatter == kind_code[2])
                        r.kind = KIND_THIRD;
                end
                if (r.kind == KIND_NONE)
                begin
                    r.status = ST_BADID;
                end
                else if (digit_bad || r.received != body_xor)
                begin
                    r.status = ST_BADSUM;
                    r.kind   = KIND_NONE;
                end
                else
                begin
                    r.status = ST_VALID;
                end
                reports_due.push_back(r);
                phase = PH_IDLE;
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        nsc_result_t got;
        nsc_result_t want;
        if (!rst_n)
        begin
            restart_sentence();
            phase        = PH_IDLE;
            kind_code[0] = RST_FIRST;
            kind_code[1] = RST_SECOND;
            kind_code[2] = RST_THIRD;
            reports_due.delete();
            mismatches   = 0;
            fail_count   = 0;
            pending     <= 0;
        end
        else
        begin
            // a result cannot leave at the edge that takes its last digit, so check before predicting
            if (m_tvalid && m_tready)
            begin
                got.kind     = m_tdata[1:0];
                got.status   = m_tdata[3:2];
                got.computed = m_tdata[11:4];
                got.received = m_tdata[19:12];
                if (reports_due.size() == 0)
                begin
                    mismatches++;
                    fail_count++;
                    if (mismatches <= ShownMax)
                        $display("%0t: result with none due: kind %0d status %0d sum %02h rx %02h",
                                 $time, got.kind, got.status, got.computed, got.received);
                end
                else
                begin
                    want = reports_due.pop_front();
                    if (got.kind !== want.kind || got.status !== want.status ||
                        got.computed !== want.computed || got.received !== want.received)
                    begin
                        mismatches++;
                        fail_count++;
                        if (mismatches <= ShownMax)
                            $display("%0t: mismatch exp kind %0d status %0d sum %02h rx %02h, got kind %0d status %0d sum %02h rx %02h",
                                     $time, want.kind, want.status, want.computed,
                                     want.received, got.kind, got.status, got.computed,
                                     got.received);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FIRST:  kind_code[0] = cfg_data;
                    REG_SECOND: kind_code[1] = cfg_data;
                    REG_THIRD:  kind_code[2] = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                take_char(s_tdata);
            pending <= reports_due.size();
        end
    end

endmodule

[tb/sv/testbench.sv]
// Top of the sentence checker bench.
//
// Stimulus is built sentence by sentence: '$', talker ID, the three formatter
// letters, a random body, '*' and two hex digits. Most sentences are well formed
// with random content; the rest carry a wrong sum, a bad digit, a '*' as digit,
// a short identifier or are cut off and restarted by the next '$'. Loose bytes
// between sentences are dropped by the block while it waits for a '$'.
//
// The monitor beside the block does all the prediction and comparing; this
// module only drives the three channels and gives the verdict.

module testbench;

    import nsc_pkg::*;

    localparam int StuckLimit = 1000;   // cycles with no transaction on any channel
    localparam int HoldCycles = 150;    // long receiver hold-off
    localparam int PhaseItems = 40;     // sentence bytes per random phase

    typedef enum int {CLEAN, BAD_SUM, BAD_DIGIT, STAR_DIGIT, SHORT_ID, CUT_OFF} flaw_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [CharW-1:0]     s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TdataOutW-1:0] m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CfgIdxW-1:0]   cfg_index;
    logic [CodeW-1:0]     cfg_data;

    int                   fail_count;
    int                   pending;
    int                   stuck;
    int                   items_sent;
    int                   phase_start;
    bit                   gapless;
    bit                   hold_req;
    logic [CodeW-1:0]     kind_code [3];   // what the registers hold right now
    logic [7:0]           line_bytes [$];
    logic [CodeW-1:0]     shared_code;

    nmea_sentence_checker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nsc_sentence_monitor monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: any transaction on any channel resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck >= StuckLimit)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver side. Runs of ready high (some long, so stretches with no
    // idling) alternate with short and occasional long stalls. A hold request
    // from the stimulus drops ready for a long stretch so the output register
    // fills and the block has to stall its input.
    initial
    begin
        int  run_left;
        bit  run_high;
        int  r;
        m_tready = 1'b0;
        run_left = 0;
        run_high = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HoldCycles) @(negedge clk);
                hold_req = 1'b0;
                run_left = 0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 45)
                    begin
                        run_high = 1'b1;
                        run_left = $urandom_range(1, 20);
                    end
                    else if (r < 55)
                    begin
                        run_high = 1'b1;
                        run_left = $urandom_range(40, 80);
                    end
                    else if (r < 90)
                    begin
                        run_high = 1'b0;
                        run_left = $urandom_range(1, 3);
                    end
                    else
                    begin
                        run_high = 1'b0;
                        run_left = $urandom_range(8, 30);
                    end
                end
                m_tready <= run_high;
                run_left--;
            end
        end
    end

    // Sender gap before each byte: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gapless || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    // Bytes right beside the hex ranges, plus the upper half of the code space.
    function automatic logic [7:0] odd_char();
        case ($urandom_range(0, 6))
            0:       return 8'h2F;
            1:       return 8'h3A;
            2:       return 8'h40;
            3:       return 8'h47;
            4:       return 8'h60;
            5:       return 8'h67;
            default: return 8'h80 | 8'($urandom_range(0, 127));
        endcase
    endfunction

    // Any byte that neither starts a sentence nor ends its body.
    function automatic logic [7:0] body_char();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_DOLLAR || b == CH_STAR)
            b = 8'h2C;
        return b;
    endfunction

    function automatic logic [CodeW-1:0] letter_code();
        return {8'(8'h41 + $urandom_range(0, 25)), 8'(8'h41 + $urandom_range(0, 25)),
                8'(8'h41 + $urandom_range(0, 25))};
    endfunction

    function automatic logic [CodeW-1:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return kind_code[$urandom_range(0, 2)];
        if (r < 90)
            return letter_code();
        return {body_char(), body_char(), body_char()};
    endfunction

    function automatic flaw_t pick_flaw();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return CLEAN;
        if (r < 77) return BAD_SUM;
        if (r < 85) return BAD_DIGIT;
        if (r < 89) return STAR_DIGIT;
        if (r < 94) return SHORT_ID;
        return CUT_OFF;
    endfunction

    // One byte transaction; valid stays up into the next byte when no gap.
    task automatic push_char(input logic [7:0] c);
        int n;
        n = pick_gap();
        repeat (n)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_line(input bit counted);
        if (counted)
            items_sent += line_bytes.size();
        foreach (line_bytes[i])
            push_char(line_bytes[i]);
        line_bytes.delete();
    endtask

    task automatic build_sentence(input logic [CodeW-1:0] fmt, input flaw_t flaw);
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] upper;
        logic [7:0] lower;
        int         n;
        sum = '0;
        line_bytes.push_back(CH_DOLLAR);
        if (flaw == SHORT_ID)
        begin
            // fewer than five ID bytes before the '*'
            n = $urandom_range(0, 4);
        end
        else
        begin
            for (int i = 0; i < 2; i++)
            begin
                b = 8'(8'h41 + $urandom_range(0, 25));
                sum ^= b;
                line_bytes.push_back(b);
            end
            for (int i = 2; i >= 0; i--)
            begin
                b = fmt[8*i +: 8];
                sum ^= b;
                line_bytes.push_back(b);
            end
            n = $urandom_range(0, 6);
        end
        repeat (n)
        begin
            b = body_char();
            sum ^= b;
            line_bytes.push_back(b);
        end
        if (flaw == CUT_OFF)
        begin
            // sometimes broken off between the two digits
            if ($urandom_range(0, 1))
            begin
                line_bytes.push_back(CH_STAR);
                line_bytes.push_back(hex_char(4'($urandom_range(0, 15)), 1'b0));
            end
            return;
        end
        line_bytes.push_back(CH_STAR);
        if (flaw == BAD_SUM)
            sum ^= 8'($urandom_range(1, 255));
        upper = hex_char(sum[7:4], 1'($urandom_range(0, 1)));
        lower = hex_char(sum[3:0], 1'($urandom_range(0, 1)));
        if (flaw == BAD_DIGIT || flaw == STAR_DIGIT)
        begin
            b = (flaw == BAD_DIGIT) ? odd_char() : CH_STAR;
            if ($urandom_range(0, 1))
                upper = b;
            else
                lower = b;
        end
        line_bytes.push_back(upper);
        line_bytes.push_back(lower);
    endtask

    task automatic sentence(input logic [CodeW-1:0] fmt, input flaw_t flaw);
        build_sentence(fmt, flaw);
        send_line(1'b1);
    endtask

    // Loose bytes between sentences; never a '$'.
    task automatic send_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 4))
        begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_DOLLAR)
                b = 8'h0A;
            line_bytes.push_back(b);
        end
        send_line(1'b0);
    endtask

    // Sender stops and waits for every outstanding report, then lets the
    // pipeline settle.
    task automatic quiesce();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CodeW-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FIRST:  kind_code[0] = val;
            REG_SECOND: kind_code[1] = val;
            REG_THIRD:  kind_code[2] = val;
            default: ;
        endcase
    endtask

    task automatic load_codes(input logic [CodeW-1:0] a, input logic [CodeW-1:0] b,
                              input logic [CodeW-1:0] c);
        write_reg(REG_FIRST, a);
        write_reg(REG_SECOND, b);
        write_reg(REG_THIRD, c);
    endtask

    initial
    begin
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        rst_n        = 1'b0;
        gapless      = 1'b0;
        hold_req     = 1'b0;
        stuck        = 0;
        items_sent   = 0;
        kind_code[0] = RST_FIRST;
        kind_code[1] = RST_SECOND;
        kind_code[2] = RST_THIRD;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, under the reset codes. Bytes before any '$' must vanish,
        // including the all-zero and all-one bytes and a stray '*'.
        line_bytes = '{8'h00, 8'hFF, CH_STAR, 8'h41};
        send_line(1'b0);
        sentence(RST_FIRST, CLEAN);
        sentence(RST_SECOND, CLEAN);
        sentence(RST_THIRD, CLEAN);
        // a '$' in the middle restarts; the broken sentence gives nothing
        sentence(RST_FIRST, CUT_OFF);
        sentence(RST_SECOND, CLEAN);
        sentence(RST_FIRST, SHORT_ID);
        sentence(RST_FIRST, BAD_DIGIT);
        sentence(RST_THIRD, STAR_DIGIT);
        sentence(24'h585958, CLEAN);        // unknown formatter
        sentence(RST_SECOND, BAD_SUM);

        // Random phases, each under its own register setting.
        for (int p = 0; p < 4; p++)
        begin
            quiesce();
            case (p)
                0: load_codes(24'h000000, 24'hFFFFFF, letter_code());
                1:
                begin
                    // equal codes: the lowest kind has to win
                    shared_code = letter_code();
                    load_codes(shared_code, shared_code, letter_code());
                end
                2:
                begin
                    load_codes(letter_code(), letter_code(), letter_code());
                    write_reg(REG_THIRD + 8'd1, letter_code());   // no such register
                end
                default: load_codes(RST_FIRST, RST_SECOND, RST_THIRD);
            endcase

            if (p == 0)
            begin
                sentence(kind_code[0], CLEAN);
                sentence(kind_code[1], CLEAN);
                sentence(kind_code[0], SHORT_ID);
            end
            if (p == 1)
            begin
                // back-to-back sentences against a stalled receiver
                hold_req = 1'b1;
                gapless  = 1'b1;
                repeat (4) sentence(kind_code[$urandom_range(0, 2)], CLEAN);
                gapless  = 1'b0;
            end

            phase_start = items_sent;
            while (items_sent - phase_start < PhaseItems)
            begin
                if ($urandom_range(0, 9) == 0)
                    gapless = ~gapless;
                sentence(pick_code(), pick_flaw());
                if ($urandom_range(0, 99) < 15)
                    send_noise();
                if ($urandom_range(0, 99) < 5)
                    quiesce();
            end
            gapless = 1'b0;
            // leave the parser idle before the next register change
            sentence(kind_code[0], CLEAN);
        end

        quiesce();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
